// ===== rtl/ulcd_pkg.sv =====
`default_nettype none
package ulcd_pkg;

  // line sizing
  localparam int LINE_MAX    = 32;
  localparam int STORE_DEPTH = LINE_MAX - 1;
  localparam int LEN_W       = $clog2(LINE_MAX);

  // command queue sizing
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // event codes
  localparam logic [2:0] EV_STATUS   = 3'd0;
  localparam logic [2:0] EV_LED_ON   = 3'd1;
  localparam logic [2:0] EV_LED_OFF  = 3'd2;
  localparam logic [2:0] EV_TOGGLE   = 3'd3;
  localparam logic [2:0] EV_RESET    = 3'd4;
  localparam logic [2:0] EV_UNKNOWN  = 3'd5;
  localparam logic [2:0] EV_OVERFLOW = 3'd6;

  // command word indexes
  localparam int NUM_CMD = 5;
  localparam logic [2:0] CMD_STATUS  = 3'd0;
  localparam logic [2:0] CMD_LED_ON  = 3'd1;
  localparam logic [2:0] CMD_LED_OFF = 3'd2;
  localparam logic [2:0] CMD_TOGGLE  = 3'd3;
  localparam logic [2:0] CMD_RESET   = 3'd4;

  // control characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // one queued command word from front to back
  typedef struct packed {
    logic       valid;
    logic [2:0] code;
  } cmd_word_t;

  // length of each command word
  function automatic logic [3:0] word_len(input logic [2:0] cmd);
    logic [3:0] l;
    case (cmd)
      CMD_STATUS:  l = 4'd6;
      CMD_LED_ON:  l = 4'd6;
      CMD_LED_OFF: l = 4'd7;
      CMD_TOGGLE:  l = 4'd10;
      CMD_RESET:   l = 4'd5;
      default:     l = 4'd0;
    endcase
    return l;
  endfunction

  // character of a command word at a position
  function automatic logic [7:0] word_char(input logic [2:0] cmd, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (cmd)
      CMD_STATUS: begin
        case (idx)
          4'd0: c = "S"; 4'd1: c = "T"; 4'd2: c = "A";
          4'd3: c = "T"; 4'd4: c = "U"; 4'd5: c = "S";
          default: c = 8'h00;
        endcase
      end
      CMD_LED_ON: begin
        case (idx)
          4'd0: c = "L"; 4'd1: c = "E"; 4'd2: c = "D";
          4'd3: c = " "; 4'd4: c = "O"; 4'd5: c = "N";
          default: c = 8'h00;
        endcase
      end
      CMD_LED_OFF: begin
        case (idx)
          4'd0: c = "L"; 4'd1: c = "E"; 4'd2: c = "D"; 4'd3: c = " ";
          4'd4: c = "O"; 4'd5: c = "F"; 4'd6: c = "F";
          default: c = 8'h00;
        endcase
      end
      CMD_TOGGLE: begin
        case (idx)
          4'd0: c = "L"; 4'd1: c = "E"; 4'd2: c = "D"; 4'd3: c = " ";
          4'd4: c = "T"; 4'd5: c = "O"; 4'd6: c = "G"; 4'd7: c = "G";
          4'd8: c = "L"; 4'd9: c = "E";
          default: c = 8'h00;
        endcase
      end
      CMD_RESET: begin
        case (idx)
          4'd0: c = "R"; 4'd1: c = "E"; 4'd2: c = "S";
          4'd3: c = "E"; 4'd4: c = "T";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ulcd_front.sv =====
`default_nettype none
module ulcd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             queue_full,
  output logic                  in_stall,
  output ulcd_pkg::cmd_word_t   push
);
  import ulcd_pkg::*;

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [NUM_CMD-1:0] match_r, match_nxt;
  logic               accept;
  logic               is_cr;
  logic               is_lf;
  logic [2:0]         line_code;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign is_cr    = (in_rx_byte == CH_CR);
  assign is_lf    = (in_rx_byte == CH_LF);

  // whole-line match at newline; words are mutually exclusive
  always_comb begin
    line_code = EV_UNKNOWN;
    for (int k = NUM_CMD - 1; k >= 0; k--) begin
      if (match_r[k] && (len_r == LEN_W'(word_len(3'(k))))) begin
        line_code = 3'(k);
      end
    end
    if (ovf_r) begin
      line_code = EV_OVERFLOW;
    end
  end

  assign push.valid = accept && is_lf && (ovf_r || (len_r != '0));
  assign push.code  = line_code;

  // line length, overflow mark and running match flags
  always_comb begin
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    match_nxt = match_r;
    if (accept) begin
      if (is_lf) begin
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        match_nxt = '1;
      end else if (!is_cr && !ovf_r) begin
        if (len_r < LEN_W'(STORE_DEPTH)) begin
          len_nxt = len_r + 1'b1;
          for (int k = 0; k < NUM_CMD; k++) begin
            match_nxt[k] = match_r[k] && (len_r < LEN_W'(word_len(3'(k))))
                           && (in_rx_byte == word_char(3'(k), len_r[3:0]));
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      match_r <= '1;
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      match_r <= match_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ulcd_queue.sv =====
`default_nettype none
module ulcd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ulcd_pkg::cmd_word_t push,
  input  wire logic                pop,
  output logic                     full,
  output ulcd_pkg::cmd_word_t      head
);
  import ulcd_pkg::*;

  logic [2:0]        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.code  = mem[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ulcd_back.sv =====
`default_nettype none
module ulcd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ulcd_pkg::cmd_word_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_event_code,
  output logic                     out_led_is_on
);
  import ulcd_pkg::*;

  logic       led_r, led_nxt;
  logic       valid_r, valid_nxt;
  logic [2:0] code_r;

  // take the next command whenever the output register is free or draining
  assign pop = head.valid && (!valid_r || !out_stall);

  // LED update for the command at the queue head
  always_comb begin
    led_nxt = led_r;
    case (head.code)
      EV_LED_ON:  led_nxt = 1'b1;
      EV_LED_OFF: led_nxt = 1'b0;
      EV_TOGGLE:  led_nxt = !led_r;
      EV_RESET:   led_nxt = 1'b0;
      default:    led_nxt = led_r;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        led_r <= led_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (pop) begin
      code_r <= head.code;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_code = code_r;
  assign out_led_is_on  = led_r;

endmodule
`default_nettype wire

// ===== rtl/uart_line_command_decoder_core.sv =====
`default_nettype none
// Line command decoder for received serial bytes. One byte word is taken per
// cycle while in_stall is low; carriage return is ignored and newline closes
// the line. Matching runs on the fly as bytes arrive (one flag per command
// word), so no line buffer is kept. A non-empty line yields one registered
// result word: event code (status, LED on, LED off, toggle, reset, unknown,
// overflow discard) and the LED state after the command. Lines longer than
// LINE_MAX-1 characters give the overflow event. A two-entry command queue
// sits between the byte classifier and the LED/output stage; in_stall rises
// only when that queue is full, i.e. when results are held back by out_stall.
module uart_line_command_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_event_code,
  output logic            out_led_is_on
);
  import ulcd_pkg::*;

  cmd_word_t push;
  cmd_word_t head;
  logic      queue_full;
  logic      pop;

  ulcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push)
  );

  ulcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (queue_full),
    .head  (head)
  );

  ulcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .out_led_is_on  (out_led_is_on)
  );

endmodule
`default_nettype wire

// ===== rtl/ulcd_checker.sv =====
`default_nettype none
module ulcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_event_code,
  input wire logic       out_led_is_on
);
  import ulcd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code)
                               && $stable(out_led_is_on))
    else $error("stalled result word changed");

  // event codes stay within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= EV_OVERFLOW)
    else $error("undefined event code");

  // LED on reports the LED lit
  a_led_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_LED_ON) |-> out_led_is_on)
    else $error("LED on without LED lit");

  // LED off and reset report the LED dark
  a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_event_code == EV_LED_OFF) || (out_event_code == EV_RESET))
    |-> !out_led_is_on)
    else $error("LED off or reset with LED lit");

  // input back-pressure only while a result word is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word waiting");

endmodule

bind uart_line_command_decoder_core ulcd_checker u_ulcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .out_led_is_on  (out_led_is_on)
);
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  import ulcd_pkg::*;

  // one byte word waiting to be sent, with its idling phase
  typedef struct {
    logic [7:0]  data;
    bit          drain_first;
    int unsigned phase;
  } rx_word_t;

  // one predicted result word
  typedef struct {
    logic [2:0] code;
    logic       led;
  } line_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  wire        in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  wire        out_valid;
  logic       out_stall = 1'b0;
  wire  [2:0] out_event_code;
  wire        out_led_is_on;

  rx_word_t    rx_words[$];
  line_event_t expected_events[$];

  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned lines_closed = 0;
  int unsigned events_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cur_phase = 0;

  // idle chance in percent per phase: sender light/heavy, then swapped, then none
  int unsigned send_idle_pct[3] = '{16, 47, 0};
  int unsigned recv_idle_pct[3] = '{47, 16, 0};

  string command_words[5] = '{"STATUS", "LED ON", "LED OFF", "LED TOGGLE", "RESET"};

  // predictor state
  logic [7:0]  line_chars [STORE_DEPTH];
  int unsigned line_len = 0;
  bit          line_ovf = 1'b0;
  bit          led_now = 1'b0;

  uart_line_command_decoder_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .out_led_is_on  (out_led_is_on)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 20) begin
      $display("ERROR %0t: result %0d, %s: expected %0d, got %0d",
               $time, events_seen, what, want, got);
    end
  endtask

  // exact match of the stored line against a command word
  function automatic bit line_is(input string w);
    if (line_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (line_chars[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the line model by one byte word, queue any result it closes
  task automatic decode_byte(input logic [7:0] b);
    line_event_t ev;
    bit          have;
    have = 1'b0;
    if (b == CH_CR) return;
    if (b == CH_LF) begin
      if (line_ovf) begin
        ev.code = EV_OVERFLOW;
        have = 1'b1;
      end else if (line_len != 0) begin
        have = 1'b1;
        if (line_is("STATUS")) begin
          ev.code = EV_STATUS;
        end else if (line_is("LED ON")) begin
          ev.code = EV_LED_ON;
          led_now = 1'b1;
        end else if (line_is("LED OFF")) begin
          ev.code = EV_LED_OFF;
          led_now = 1'b0;
        end else if (line_is("LED TOGGLE")) begin
          ev.code = EV_TOGGLE;
          led_now = !led_now;
        end else if (line_is("RESET")) begin
          ev.code = EV_RESET;
          led_now = 1'b0;
        end else begin
          ev.code = EV_UNKNOWN;
        end
      end
      line_len = 0;
      line_ovf = 1'b0;
      if (have) begin
        ev.led = led_now;
        expected_events.push_back(ev);
        lines_closed++;
      end
    end else if (!line_ovf) begin
      if (line_len < STORE_DEPTH) begin
        line_chars[line_len] = b;
        line_len++;
      end else begin
        line_ovf = 1'b1;
      end
    end
  endtask

  task automatic add_word(input logic [7:0] b, input bit drain);
    rx_word_t w;
    w.data = b;
    w.drain_first = drain;
    w.phase = (words_queued < 340) ? 0 : (words_queued < 680) ? 1 : 2;
    rx_words.push_back(w);
    words_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_word(s[i], 1'b0);
  endtask

  // any byte but newline
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_LF) b = 8'hFF;
    return b;
  endfunction

  // one random line: mostly commands, plus empty lines, near misses, noise and long lines
  task automatic add_random_line(input bit force_drain);
    logic [7:0]  body[$];
    string       cmd;
    int unsigned kind;
    int unsigned n;
    bit          drain;
    kind = $urandom_range(99);
    drain = force_drain || ($urandom_range(99) < 3);
    cmd = command_words[$urandom_range(4)];
    if (kind < 55) begin
      for (int i = 0; i < cmd.len(); i++) body.push_back(cmd[i]);
    end else if (kind < 65) begin
      // empty line
    end else if (kind < 78) begin
      for (int i = 0; i < cmd.len(); i++) body.push_back(cmd[i]);
      case ($urandom_range(3))
        0: body[$urandom_range(body.size() - 1)] = noise_byte();
        1: void'(body.pop_back());
        2: body.push_back(noise_byte());
        default: body.insert($urandom_range(body.size()), 8'h00);
      endcase
    end else if (kind < 90) begin
      n = $urandom_range(1, 12);
      repeat (n) body.push_back(noise_byte());
    end else begin
      // around the store limit, and well past it
      n = $urandom_range(1) ? $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 2)
                            : $urandom_range(STORE_DEPTH + 3, STORE_DEPTH + 14);
      repeat (n) body.push_back($urandom_range(1) ? noise_byte()
                                                  : 8'(cmd[$urandom_range(cmd.len() - 1)]));
    end
    // stray carriage returns, and CRLF endings
    if ($urandom_range(99) < 25) body.insert($urandom_range(body.size()), CH_CR);
    if ($urandom_range(99) < 30) body.push_back(CH_CR);
    foreach (body[i]) add_word(body[i], (i == 0) ? drain : 1'b0);
    add_word(CH_LF, (body.size() == 0) ? drain : 1'b0);
  endtask

  // sender: present the head word, hold it while stalled
  always @(posedge clk) begin : drive_words
    bit present;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_rx_byte);
        words_taken++;
        void'(rx_words.pop_front());
      end
      if (in_valid && in_stall) begin
        present = 1'b1;
      end else if (rx_words.size() == 0) begin
        present = 1'b0;
      end else if (rx_words[0].drain_first && expected_events.size() != 0) begin
        // hold off until every outstanding result is back
        present = 1'b0;
      end else begin
        cur_phase = rx_words[0].phase;
        present = ($urandom_range(99) >= send_idle_pct[cur_phase]);
      end
      in_valid <= present;
      if (present) in_rx_byte <= rx_words[0].data;
    end
  end

  // receiver: random stall, check each taken result against the oldest prediction
  always @(posedge clk) begin : watch_results
    line_event_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          report_mismatch("result with none outstanding", 0, out_event_code);
        end else begin
          want = expected_events.pop_front();
          if (out_event_code !== want.code) begin
            report_mismatch("event code", want.code, out_event_code);
          end
          if (out_led_is_on !== want.led) begin
            report_mismatch("LED state", want.led, out_led_is_on);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct[cur_phase]);
    end
  end

  initial begin
    foreach (line_chars[i]) line_chars[i] = 8'h00;

    // directed: CRLF command, empty line, zero and top byte, toggle
    add_text("LED ON");
    add_word(CH_CR, 1'b0);
    add_word(CH_LF, 1'b0);
    add_word(CH_LF, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(CH_LF, 1'b0);
    add_text("LED TOGGLE");
    add_word(CH_LF, 1'b0);

    add_random_line(1'b1);
    while (words_queued < 1020) add_random_line(1'b0);

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_words.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d byte words closing %0d non-empty lines; %0d results checked",
             words_taken, lines_closed, events_seen);
    $display("Covered all commands, unknown and zero-byte lines, overflow, CR and empty lines");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ulcd_pkg.sv
rtl/ulcd_front.sv
rtl/ulcd_queue.sv
rtl/ulcd_back.sv
rtl/uart_line_command_decoder_core.sv
rtl/ulcd_checker.sv
dv/testbench.sv
